// ===== rtl/mpba_pkg.sv =====
// ----------------------------------------------------------------------------
// mpba_pkg
// Shared types, sizes and codes of the multi-pool budget admission block.
// ----------------------------------------------------------------------------
package mpba_pkg;

    localparam int NUM_POOLS = 4;
    localparam int POOL_AW   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int BYTE_W    = 48;
    localparam int FUNC_W    = 2;
    localparam int PIDX_W    = 3;
    localparam int STAT_W    = 3;
    localparam int KIND_W    = 2;
    localparam int ERR_W     = 2;

    localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_CAP = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_BAD     = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD         = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVER_USED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_CAP_REFUSED = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MIXED = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PIDX_W-1:0] pool_index;
        logic [BYTE_W-1:0] byte_count;
        logic              last_of_request;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] pool_used;
        logic [BYTE_W-1:0] pool_peak;
        logic [BYTE_W-1:0] pool_capacity;
        logic              invariant_ok;
    } t_out_item;

endpackage

// ===== rtl/mpba_in_reg.sv =====
// ----------------------------------------------------------------------------
// mpba_in_reg
// Input register: holds one item until the pool core takes it.
// ----------------------------------------------------------------------------
module mpba_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mpba_pkg::t_in_item i_in_data,
    input  logic              i_take,
    output logic              o_item_valid,
    output mpba_pkg::t_in_item o_item
);
    import mpba_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_in_ready   = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_in_valid && o_in_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

endmodule

// ===== rtl/mpba_pool_core.sv =====
// ----------------------------------------------------------------------------
// mpba_pool_core
// Pool stores, open request sums and the admit decision, with the result
// register; result fields are read from the stores, which hold still while
// a result waits.
// ----------------------------------------------------------------------------
module mpba_pool_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_frozen,
    input  logic                i_item_valid,
    input  mpba_pkg::t_in_item  i_item,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mpba_pkg::t_out_item o_out_data
);
    import mpba_pkg::*;

    logic [BYTE_W-1:0] r_cap  [NUM_POOLS];
    logic [BYTE_W-1:0] r_used [NUM_POOLS];
    logic [BYTE_W-1:0] r_peak [NUM_POOLS];
    logic [BYTE_W-1:0] r_sum  [NUM_POOLS];
    logic [KIND_W-1:0] r_kind;
    logic [ERR_W-1:0]  r_err;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [PIDX_W-1:0] r_pool;

    logic [BYTE_W-1:0] n_cap  [NUM_POOLS];
    logic [BYTE_W-1:0] n_used [NUM_POOLS];
    logic [BYTE_W-1:0] n_peak [NUM_POOLS];
    logic [BYTE_W-1:0] n_sum  [NUM_POOLS];
    logic [KIND_W-1:0] n_kind;
    logic [ERR_W-1:0]  n_err;
    logic [STAT_W-1:0] n_status;

    logic [BYTE_W-1:0] sum_eff  [NUM_POOLS];
    logic [BYTE_W-1:0] used_add [NUM_POOLS];
    logic [BYTE_W:0]   add_wide;
    logic [BYTE_W-1:0] room;
    logic [POOL_AW-1:0] addr;
    logic              pool_ok;
    logic              elem_ovf;
    logic              no_fit;
    logic              over_used;
    logic              gives_result;
    logic [KIND_W-1:0] kind_f;
    logic [KIND_W-1:0] kind_next;
    logic [ERR_W-1:0]  err_next;

    logic [POOL_AW-1:0] out_addr;
    logic               out_pool_ok;
    logic               inv_ok;

    assign addr    = i_item.pool_index[POOL_AW-1:0];
    assign pool_ok = int'(i_item.pool_index) < NUM_POOLS;

    assign gives_result = (i_item.func == FUNC_SET_CAP) || (i_item.func == FUNC_BAD)
                          || i_item.last_of_request;
    assign o_take = i_item_valid && (!gives_result || !r_out_valid || i_out_ready);

    // per-pool accumulate and admit checks
    always_comb begin
        elem_ovf  = 1'b0;
        no_fit    = 1'b0;
        over_used = 1'b0;
        add_wide  = '0;
        room      = '0;
        for (int i = 0; i < NUM_POOLS; i++) begin
            if (pool_ok && (int'(addr) == i)) begin
                add_wide = {1'b0, r_sum[i]} + {1'b0, i_item.byte_count};
            end else begin
                add_wide = {1'b0, r_sum[i]};
            end
            if (add_wide[BYTE_W]) begin
                elem_ovf   = 1'b1;
                sum_eff[i] = r_sum[i];
            end else begin
                sum_eff[i] = add_wide[BYTE_W-1:0];
            end
            room = (r_used[i] > r_cap[i]) ? '0 : r_cap[i] - r_used[i];
            if (sum_eff[i] > room) begin
                no_fit = 1'b1;
            end
            if (sum_eff[i] > r_used[i]) begin
                over_used = 1'b1;
            end
            used_add[i] = r_used[i] + sum_eff[i];
        end
    end

    always_comb begin
        kind_f    = (i_item.func == FUNC_RESERVE) ? KIND_RESERVE : KIND_RELEASE;
        kind_next = (r_kind == KIND_NONE) ? kind_f : r_kind;
        if ((r_kind != KIND_NONE) && (r_kind != kind_f)) begin
            err_next = ERR_MIXED;
        end else begin
            err_next = r_err;
        end
        if ((err_next == ERR_NONE) && (!pool_ok || elem_ovf)) begin
            err_next = ERR_BAD;
        end
    end

    always_comb begin
        n_cap    = r_cap;
        n_used   = r_used;
        n_peak   = r_peak;
        n_sum    = r_sum;
        n_kind   = r_kind;
        n_err    = r_err;
        n_status = ST_OK;
        unique case (i_item.func)
            FUNC_SET_CAP: begin
                if (!pool_ok) begin
                    n_status = ST_BAD;
                end else if (i_frozen || (i_item.byte_count < r_used[addr])) begin
                    n_status = ST_CAP_REFUSED;
                end else begin
                    n_cap[addr] = i_item.byte_count;
                end
            end
            FUNC_RESERVE, FUNC_RELEASE: begin
                if (!i_item.last_of_request) begin
                    n_sum  = sum_eff;
                    n_kind = kind_next;
                    n_err  = err_next;
                end else begin
                    for (int i = 0; i < NUM_POOLS; i++) begin
                        n_sum[i] = '0;
                    end
                    n_kind = KIND_NONE;
                    n_err  = ERR_NONE;
                    if (err_next != ERR_NONE) begin
                        n_status = ST_BAD;
                    end else if (kind_next == KIND_RESERVE) begin
                        if (no_fit) begin
                            n_status = ST_NO_ROOM;
                        end else begin
                            for (int i = 0; i < NUM_POOLS; i++) begin
                                n_used[i] = used_add[i];
                                if (used_add[i] > r_peak[i]) begin
                                    n_peak[i] = used_add[i];
                                end
                            end
                        end
                    end else begin
                        if (over_used) begin
                            n_status = ST_OVER_USED;
                        end else begin
                            for (int i = 0; i < NUM_POOLS; i++) begin
                                n_used[i] = r_used[i] - sum_eff[i];
                            end
                        end
                    end
                end
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POOLS; i++) begin
                r_cap[i]  <= '0;
                r_used[i] <= '0;
                r_peak[i] <= '0;
                r_sum[i]  <= '0;
            end
            r_kind      <= KIND_NONE;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_cap  <= n_cap;
                r_used <= n_used;
                r_peak <= n_peak;
                r_sum  <= n_sum;
                r_kind <= n_kind;
                r_err  <= n_err;
            end
            if (o_take && gives_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && gives_result) begin
            r_status <= n_status;
            r_pool   <= i_item.pool_index;
        end
    end

    // result fields from the stores
    assign out_addr    = r_pool[POOL_AW-1:0];
    assign out_pool_ok = int'(r_pool) < NUM_POOLS;

    always_comb begin
        inv_ok = 1'b1;
        for (int i = 0; i < NUM_POOLS; i++) begin
            if ((r_used[i] > r_cap[i]) || (r_peak[i] > r_cap[i])) begin
                inv_ok = 1'b0;
            end
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.status       = r_status;
    assign o_out_data.pool_used    = out_pool_ok ? r_used[out_addr] : '0;
    assign o_out_data.pool_peak    = out_pool_ok ? r_peak[out_addr] : '0;
    assign o_out_data.pool_capacity = out_pool_ok ? r_cap[out_addr] : '0;
    assign o_out_data.invariant_ok = inv_ok;

endmodule

// ===== rtl/multi_pool_budget_admission_top.sv =====
// ----------------------------------------------------------------------------
// multi_pool_budget_admission_top
// Path: an input transfer is held in the input register, then its decision
// is written into the result register.
// Throughput: one item per cycle; items that give a result wait only while
// an earlier result is not yet taken, other request elements wait only behind
// such a stalled item.
// Reset clears all pool stores, the open request and the frozen flag at once.
// ----------------------------------------------------------------------------
module multi_pool_budget_admission_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mpba_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mpba_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import mpba_pkg::*;

    logic     r_capacity_frozen;
    logic     w_take;
    logic     w_item_valid;
    t_in_item w_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity_frozen <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity_frozen <= i_cfg_data;
        end
    end

    mpba_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_take       (w_take),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    mpba_pool_core u_pool_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frozen     (r_capacity_frozen),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    a_setcap_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_item.func == FUNC_SET_CAP)) |=> o_out_valid)
        else $error("set capacity gave no result");

    a_element_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_item.last_of_request && !o_out_valid
         && ((w_item.func == FUNC_RESERVE) || (w_item.func == FUNC_RELEASE)))
        |=> !o_out_valid)
        else $error("non-final element gave a result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_CAP_REFUSED))
        else $error("status code out of range");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_valid && !w_take) |=> (w_item_valid && $stable(w_item)))
        else $error("stalled item lost in input register");

endmodule

// ===== bench/multi_pool_budget_admission_top_tb.sv =====
// ----------------------------------------------------------------------------
// multi_pool_budget_admission_top_tb
// Drives reserve, release, set-capacity and bad-function transfers into the admission block
// with random gaps and stalls on both channels. A local model of the pool
// stores predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module multi_pool_budget_admission_top_tb;

    import mpba_pkg::*;

    localparam logic [BYTE_W-1:0] BYTES_MAX = '1;
    localparam logic [BYTE_W-1:0] TOP_BIT   = {1'b1, {(BYTE_W-1){1'b0}}};
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int MAX_PRINTS     = 100;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data  = 1'b0;

    multi_pool_budget_admission_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predicted pool state
    logic [BYTE_W-1:0] cap_q  [NUM_POOLS];
    logic [BYTE_W-1:0] used_q [NUM_POOLS];
    logic [BYTE_W-1:0] peak_q [NUM_POOLS];
    logic [BYTE_W-1:0] sum_q  [NUM_POOLS];
    logic [ERR_W-1:0]  req_err;
    logic [KIND_W-1:0] req_kind;
    logic              frozen_q;

    t_in_item    pending_items[$];
    t_out_item   expected_results[$];
    int unsigned items_added = 0;
    int unsigned errors      = 0;

    int unsigned in_xfers      = 0;
    int unsigned in_xfers_seen = 0;
    bit          in_busy       = 1'b0;
    int unsigned in_gap_left   = 0;
    int unsigned out_gap_left  = 0;
    int unsigned in_idle_pct   = 0;
    int unsigned out_idle_pct  = 0;
    int unsigned hold_reqs     = 0;
    int unsigned holds_done    = 0;
    int unsigned hold_left     = 0;

    function automatic void clear_open_request();
        foreach (sum_q[i]) sum_q[i] = '0;
        req_err  = ERR_NONE;
        req_kind = KIND_NONE;
    endfunction

    function automatic void reset_pools();
        foreach (cap_q[i]) begin
            cap_q[i]  = '0;
            used_q[i] = '0;
            peak_q[i] = '0;
        end
        clear_open_request();
        frozen_q = 1'b0;
    endfunction

    function automatic t_out_item pool_report(logic [STAT_W-1:0] st,
                                              logic [PIDX_W-1:0] pool);
        t_out_item          r;
        logic [POOL_AW-1:0] a;
        r = '0;
        a = pool[POOL_AW-1:0];
        r.status = st;
        r.invariant_ok = 1'b1;
        for (int i = 0; i < NUM_POOLS; i++)
            if (used_q[i] > cap_q[i] || peak_q[i] > cap_q[i]) r.invariant_ok = 1'b0;
        if (pool < NUM_POOLS) begin
            r.pool_used     = used_q[a];
            r.pool_peak     = peak_q[a];
            r.pool_capacity = cap_q[a];
        end
        return r;
    endfunction

    function automatic bit predict_admission(t_in_item it, output t_out_item res);
        logic [STAT_W-1:0]  st;
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W:0]    total;
        logic [BYTE_W-1:0]  room;
        logic [POOL_AW-1:0] a;
        st  = ST_OK;
        res = '0;
        a   = it.pool_index[POOL_AW-1:0];
        if (it.func == FUNC_SET_CAP) begin
            if (it.pool_index >= NUM_POOLS)
                st = ST_BAD;
            else if (frozen_q || it.byte_count < used_q[a])
                st = ST_CAP_REFUSED;
            else
                cap_q[a] = it.byte_count;
            res = pool_report(st, it.pool_index);
            return 1'b1;
        end
        if (it.func == FUNC_BAD) begin
            res = pool_report(ST_BAD, it.pool_index);
            return 1'b1;
        end
        kind = (it.func == FUNC_RESERVE) ? KIND_RESERVE : KIND_RELEASE;
        if (req_kind == KIND_NONE)
            req_kind = kind;
        else if (req_kind != kind)
            req_err = ERR_MIXED;
        if (it.pool_index >= NUM_POOLS) begin
            if (req_err == ERR_NONE) req_err = ERR_BAD;
        end else begin
            total = {1'b0, sum_q[a]} + {1'b0, it.byte_count};
            if (total[BYTE_W]) begin
                if (req_err == ERR_NONE) req_err = ERR_BAD;
            end else begin
                sum_q[a] = total[BYTE_W-1:0];
            end
        end
        if (!it.last_of_request) return 1'b0;
        if (req_err != ERR_NONE) begin
            st = ST_BAD;
        end else if (req_kind == KIND_RESERVE) begin
            for (int i = 0; i < NUM_POOLS; i++) begin
                room = (used_q[i] > cap_q[i]) ? '0 : cap_q[i] - used_q[i];
                if (sum_q[i] > room) st = ST_NO_ROOM;
            end
            if (st == ST_OK)
                for (int i = 0; i < NUM_POOLS; i++) begin
                    used_q[i] = used_q[i] + sum_q[i];
                    if (used_q[i] > peak_q[i]) peak_q[i] = used_q[i];
                end
        end else begin
            for (int i = 0; i < NUM_POOLS; i++)
                if (sum_q[i] > used_q[i]) st = ST_OVER_USED;
            if (st == ST_OK)
                for (int i = 0; i < NUM_POOLS; i++) used_q[i] = used_q[i] - sum_q[i];
        end
        clear_open_request();
        res = pool_report(st, it.pool_index);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [BYTE_W-1:0] want,
                                   logic [BYTE_W-1:0] got);
        if (errors < MAX_PRINTS)
            $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
        errors++;
    endtask

    // transfers are observed at the rising edge
    always @(posedge i_clk) begin : monitor
        t_out_item predicted;
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) frozen_q = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                in_xfers++;
                if (predict_admission(i_in_data, predicted)) expected_results.push_back(predicted);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none pending, status", '0,
                                    BYTE_W'(o_out_data.status));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", BYTE_W'(want.status),
                                        BYTE_W'(o_out_data.status));
                    if (o_out_data.pool_used !== want.pool_used)
                        report_mismatch("pool_used", want.pool_used, o_out_data.pool_used);
                    if (o_out_data.pool_peak !== want.pool_peak)
                        report_mismatch("pool_peak", want.pool_peak, o_out_data.pool_peak);
                    if (o_out_data.pool_capacity !== want.pool_capacity)
                        report_mismatch("pool_capacity", want.pool_capacity,
                                        o_out_data.pool_capacity);
                    if (o_out_data.invariant_ok !== want.invariant_ok)
                        report_mismatch("invariant_ok", BYTE_W'(want.invariant_ok),
                                        BYTE_W'(o_out_data.invariant_ok));
                end
            end
        end
    end

    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(99, 0) >= pct) return 0;
        if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    always @(negedge i_clk) begin : item_driver
        logic     next_valid;
        t_in_item next_data;
        next_valid = i_in_valid;
        next_data  = i_in_data;
        if (in_busy && in_xfers != in_xfers_seen) begin
            in_xfers_seen = in_xfers;
            in_busy       = 1'b0;
            next_valid    = 1'b0;
        end
        if (i_rst_n && !in_busy) begin
            if (in_gap_left > 0) begin
                in_gap_left--;
            end else if (pending_items.size() != 0) begin
                next_data   = pending_items.pop_front();
                next_valid  = 1'b1;
                in_busy     = 1'b1;
                in_gap_left = pick_gap(in_idle_pct);
            end
        end
        i_in_valid <= next_valid;
        i_in_data  <= next_data;
    end

    always @(negedge i_clk) begin : result_sink
        if (hold_reqs != holds_done) begin
            holds_done = hold_reqs;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap_left > 0) begin
            out_gap_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready  <= 1'b1;
            out_gap_left = pick_gap(out_idle_pct);
        end
    end

    task automatic add_item(logic [FUNC_W-1:0] f, logic [PIDX_W-1:0] p,
                            logic [BYTE_W-1:0] b, logic last);
        t_in_item it;
        it.func            = f;
        it.pool_index      = p;
        it.byte_count      = b;
        it.last_of_request = last;
        pending_items.push_back(it);
        items_added++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_bytes(int unsigned maxw);
        int unsigned w;
        logic [63:0] r;
        w = $urandom_range(maxw, 0);
        r = {$urandom(), $urandom()};
        if (w == 0) return '0;
        r = r >> (64 - w);
        return r[BYTE_W-1:0];
    endfunction

    function automatic logic [PIDX_W-1:0] valid_pool();
        return PIDX_W'($urandom_range(NUM_POOLS - 1, 0));
    endfunction

    function automatic logic [PIDX_W-1:0] bad_pool();
        return PIDX_W'($urandom_range(7, NUM_POOLS));
    endfunction

    function automatic logic rand_bit();
        return ($urandom_range(1, 0) != 0);
    endfunction

    function automatic logic [PIDX_W-1:0] any_pool();
        if ($urandom_range(7, 0) == 0) return bad_pool();
        return valid_pool();
    endfunction

    task automatic add_request(logic [FUNC_W-1:0] f, int unsigned elems, int unsigned maxw);
        for (int unsigned e = 0; e < elems; e++)
            add_item(f, valid_pool(), rand_bytes(maxw), e == elems - 1);
    endtask

    task automatic random_phase(int unsigned n);
        int unsigned start;
        int unsigned pick;
        logic [PIDX_W-1:0] p;
        logic [FUNC_W-1:0] f;
        start = items_added;
        while (items_added - start < n) begin
            pick = $urandom_range(99, 0);
            p    = valid_pool();
            f    = rand_bit() ? FUNC_RESERVE : FUNC_RELEASE;
            if (pick < 45) begin
                add_request(FUNC_RESERVE, $urandom_range(4, 1),
                            ($urandom_range(3, 0) == 0) ? 48 : $urandom_range(30, 4));
            end else if (pick < 75) begin
                add_request(FUNC_RELEASE, $urandom_range(3, 1), $urandom_range(28, 0));
            end else if (pick < 85) begin
                add_item(FUNC_SET_CAP, any_pool(),
                         ($urandom_range(9, 0) == 0) ? BYTES_MAX : rand_bytes(48),
                         rand_bit());
            end else if (pick < 89) begin
                add_item(FUNC_BAD, PIDX_W'($urandom_range(7, 0)), rand_bytes(48), rand_bit());
            end else if (pick < 93) begin
                // mixed kinds
                add_item(f, p, rand_bytes(20), 1'b0);
                add_item(f ^ 2'd1, valid_pool(), rand_bytes(20), 1'b1);
            end else if (pick < 96) begin
                // bad pool inside a request
                add_item(f, p, rand_bytes(20), 1'b0);
                add_item(f, bad_pool(), rand_bytes(48), 1'b1);
            end else if (pick < 98) begin
                // per-pool sum overflow
                add_item(f, p, TOP_BIT | rand_bytes(47), 1'b0);
                add_item(f, p, TOP_BIT | rand_bytes(47), 1'b1);
            end else begin
                // set capacity inside an open request
                add_item(FUNC_RESERVE, p, rand_bytes(16), 1'b0);
                add_item(FUNC_SET_CAP, p, rand_bytes(48), rand_bit());
                add_item(FUNC_RESERVE, p, rand_bytes(16), 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_busy || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_frozen(logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        reset_pools();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct  = 20;
        out_idle_pct = 20;
        add_item(FUNC_RESERVE, 0, 0, 1'b1);
        add_item(FUNC_SET_CAP, 0, BYTES_MAX, 1'b0);
        add_item(FUNC_SET_CAP, 1, 1000, 1'b1);
        add_item(FUNC_SET_CAP, 2, 1000, 1'b0);
        add_item(FUNC_SET_CAP, 4, 77, 1'b0);
        add_item(FUNC_SET_CAP, 7, BYTES_MAX, 1'b1);
        add_item(FUNC_RESERVE, 0, BYTES_MAX - 5, 1'b0);
        add_item(FUNC_RESERVE, 1, 600, 1'b0);
        add_item(FUNC_RESERVE, 1, 400, 1'b1);
        add_item(FUNC_RESERVE, 1, 1, 1'b1);
        add_item(FUNC_SET_CAP, 1, 999, 1'b0);
        add_item(FUNC_RELEASE, 1, 1000, 1'b0);
        add_item(FUNC_RELEASE, 0, BYTES_MAX - 5, 1'b1);
        add_item(FUNC_SET_CAP, 1, 10, 1'b0);
        add_item(FUNC_RELEASE, 2, 1, 1'b1);
        add_item(FUNC_RESERVE, 0, BYTES_MAX, 1'b0);
        add_item(FUNC_RESERVE, 0, 1, 1'b1);
        add_item(FUNC_RESERVE, 2, 5, 1'b0);
        add_item(FUNC_RELEASE, 2, 5, 1'b1);
        add_item(FUNC_RESERVE, 5, 3, 1'b1);
        add_item(FUNC_BAD, 2, BYTES_MAX, 1'b1);
        add_item(FUNC_BAD, 6, 0, 1'b0);
        add_item(FUNC_RESERVE, 2, 100, 1'b0);
        add_item(FUNC_SET_CAP, 2, 2000, 1'b0);
        add_item(FUNC_RESERVE, 2, 1500, 1'b1);
        wait_idle();

        write_frozen(1'b1);
        add_item(FUNC_SET_CAP, 0, 5, 1'b1);
        add_item(FUNC_SET_CAP, 6, 5, 1'b0);
        add_item(FUNC_RELEASE, 3, 0, 1'b1);
        wait_idle();

        write_frozen(1'b0);
        in_idle_pct  = 30;
        out_idle_pct = 30;
        random_phase(300);
        wait_idle();
        random_phase(250);
        wait_idle();

        write_frozen(1'b1);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_phase(300);
        wait_idle();

        write_frozen(1'b0);
        in_idle_pct  = 10;
        out_idle_pct = 40;
        random_phase(250);
        hold_reqs++;
        random_phase(250);
        wait_idle();

        write_frozen(1'b1);
        in_idle_pct  = 25;
        out_idle_pct = 10;
        random_phase(60);
        wait_idle();

        if (errors == 0)
            $display("multi_pool_budget_admission_top_tb OK");
        else
            $display("multi_pool_budget_admission_top_tb NOT OK");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 8);
        $display("multi_pool_budget_admission_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mpba_pkg.sv
rtl/mpba_in_reg.sv
rtl/mpba_pool_core.sv
rtl/multi_pool_budget_admission_top.sv
bench/multi_pool_budget_admission_top_tb.sv
